@@ rtl/qsm_pkg.sv @@
// ----------------------------------------------------------------------------
// qsm_pkg: shared types and constants for the quadrature speed meter
// Holds the sequencer states, register indexes and the fixed-point scale
// used by the RPM calculation.
// ----------------------------------------------------------------------------
`default_nettype none

package qsm_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_UPDATE_PERIOD  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PULSES_PER_REV = 1'd1;

  localparam int CFG_DATA_W = 16;

  // Reset values of the configuration registers
  localparam logic [CFG_DATA_W-1:0] PERIOD_RESET = 16'd50;
  localparam logic [CFG_DATA_W-1:0] PPR_RESET    = 16'd360;

  // 60000 ms per minute times 256 for Q.8
  localparam logic [31:0] MS_Q8_SCALE = 32'd15360000;

  // Widths of the speed datapath
  localparam int SPEED_W = 24;
  localparam int NUM_W   = 55;  // |delta| <= 2^31 times scale < 2^24
  localparam int DEN_W   = 48;  // 16-bit ppr times 32-bit elapsed
  localparam int STEP_W  = 5;   // counts quotient bits 23..0

  localparam logic [SPEED_W-1:0] SPEED_MAX = 24'h7FFFFF;
  localparam logic [SPEED_W-1:0] SPEED_MIN = 24'h800000;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_NUM,
    ST_MUL_DEN,
    ST_CHECK,
    ST_DIV,
    ST_FINISH,
    ST_OUT
  } qsm_state_t;

endpackage : qsm_pkg

`default_nettype wire

@@ rtl/quadrature_speed_meter_unit.sv @@
// ----------------------------------------------------------------------------
// quadrature_speed_meter_unit: X1 quadrature counter with windowed RPM
// Counts rising edges of line A (direction from line B) and, when a window
// closes, computes the speed in signed Q15.8 RPM with a shared multiplier
// and a shared compare/subtract unit doing restoring division.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+-------------------------------
//   in_      | input     | in_valid/in_stall  | line_a, line_b, time_ms
//   out_     | output    | out_valid/out_stall| position, speed_rpm_q8,
//            |           |                    | speed_updated
//   cfg_     | input     | cfg_we             | cfg_index, cfg_wdata
//
// A sample that does not close a window goes from idle straight to the load
// step. A sample that closes a window passes through two multiplier passes,
// one overflow compare, 24 restoring division steps, sign/saturate and load;
// a compare that shows saturation skips the division. in_stall is high
// whenever the sequencer is not idle.
// A result waits in the output register while out_stall is high; the next
// sample can be taken meanwhile, and its load step waits for the register.
// rst_n is synchronous and active low; it clears counters and control state.
// ----------------------------------------------------------------------------
`default_nettype none

module quadrature_speed_meter_unit
  import qsm_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // configuration
  input  wire logic                         cfg_we,
  input  wire logic [CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [CFG_DATA_W-1:0]        cfg_wdata,
  // input samples
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_line_a,
  input  wire logic                         in_line_b,
  input  wire logic [31:0]                  in_time_ms,
  // results
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic signed [31:0]                out_position,
  output logic signed [SPEED_W-1:0]         out_speed_rpm_q8,
  output logic                              out_speed_updated
);

  // Registers
  qsm_state_t              state_r, state_nxt;
  logic [CFG_DATA_W-1:0]   period_r, ppr_r;
  logic                    prev_a_r, prev_a_nxt;
  logic [31:0]             count_r, count_nxt;
  logic [31:0]             win_count_r, win_count_nxt;
  logic [31:0]             win_time_r, win_time_nxt;
  logic [SPEED_W-1:0]      held_r, held_nxt;
  logic                    upd_r, upd_nxt;
  logic                    neg_r, neg_nxt;
  logic                    sat_r, sat_nxt;
  logic [31:0]             mag_r, mag_nxt;
  logic [31:0]             elapsed_r, elapsed_nxt;
  logic [NUM_W-1:0]        num_r, num_nxt;
  logic [DEN_W-1:0]        den_r, den_nxt;
  logic [DEN_W-1:0]        rem_r, rem_nxt;
  logic [SPEED_W-1:0]      quot_r, quot_nxt;
  logic [STEP_W-1:0]       step_r, step_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [31:0]             out_pos_r, out_pos_nxt;
  logic [SPEED_W-1:0]      out_speed_r, out_speed_nxt;
  logic                    out_upd_r, out_upd_nxt;

  // Combinational helpers
  logic                    in_xfer, out_xfer, out_free;
  logic [CFG_DATA_W-1:0]   period_eff, ppr_eff;
  logic [31:0]             count_inc, delta, elapsed_now;
  logic [31:0]             mul_a, mul_b;
  logic [63:0]             mul_p;
  logic [DEN_W:0]          sub_a;
  logic [DEN_W+1:0]        sub_diff;
  logic                    sub_borrow;
  logic [SPEED_W-1:0]      num_lo;
  logic                    sat_any;

  assign in_xfer  = in_valid && !in_stall;
  assign out_xfer = out_valid_r && !out_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign period_eff = (period_r == '0) ? CFG_DATA_W'(1) : period_r;
  assign ppr_eff    = (ppr_r == '0) ? CFG_DATA_W'(1) : ppr_r;

  // Count a rising edge on A, direction from B
  always_comb begin
    count_inc = count_r;
    if (in_line_a && !prev_a_r) begin
      count_inc = in_line_b ? (count_r + 32'd1) : (count_r - 32'd1);
    end
  end

  assign elapsed_now = in_time_ms - win_time_r;
  assign delta       = count_inc - win_count_r;

  // Shared multiplier: scale times |delta|, then ppr times elapsed
  always_comb begin
    if (state_r == ST_MUL_DEN) begin
      mul_a = elapsed_r;
      mul_b = {16'd0, ppr_eff};
    end else begin
      mul_a = mag_r;
      mul_b = MS_Q8_SCALE;
    end
  end
  assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

  // Shared subtractor: overflow check, then one division step per cycle
  assign num_lo = num_r[SPEED_W-1:0];
  always_comb begin
    if (state_r == ST_CHECK) begin
      sub_a = (DEN_W+1)'(num_r[NUM_W-1:SPEED_W]);
    end else begin
      sub_a = {rem_r, num_lo[step_r]};
    end
  end
  assign sub_diff   = {1'b0, sub_a} - {2'b00, den_r};
  assign sub_borrow = sub_diff[DEN_W+1];
  assign sat_any    = sat_r || quot_r[SPEED_W-1];

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and datapath
  always_comb begin
    state_nxt     = state_r;
    prev_a_nxt    = prev_a_r;
    count_nxt     = count_r;
    win_count_nxt = win_count_r;
    win_time_nxt  = win_time_r;
    held_nxt      = held_r;
    upd_nxt       = upd_r;
    neg_nxt       = neg_r;
    sat_nxt       = sat_r;
    mag_nxt       = mag_r;
    elapsed_nxt   = elapsed_r;
    num_nxt       = num_r;
    den_nxt       = den_r;
    rem_nxt       = rem_r;
    quot_nxt      = quot_r;
    step_nxt      = step_r;
    out_valid_nxt = out_xfer ? 1'b0 : out_valid_r;
    out_pos_nxt   = out_pos_r;
    out_speed_nxt = out_speed_r;
    out_upd_nxt   = out_upd_r;
    in_stall      = (state_r != ST_IDLE);

    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          prev_a_nxt = in_line_a;
          count_nxt  = count_inc;
          upd_nxt    = 1'b0;
          state_nxt  = ST_OUT;
          if (elapsed_now >= {16'd0, period_eff}) begin
            upd_nxt       = 1'b1;
            neg_nxt       = delta[31];
            mag_nxt       = delta[31] ? (32'd0 - delta) : delta;
            elapsed_nxt   = elapsed_now;
            win_count_nxt = count_inc;
            win_time_nxt  = in_time_ms;
            state_nxt     = ST_MUL_NUM;
          end
        end
      end
      ST_MUL_NUM: begin
        num_nxt   = mul_p[NUM_W-1:0];
        state_nxt = ST_MUL_DEN;
      end
      ST_MUL_DEN: begin
        den_nxt   = mul_p[DEN_W-1:0];
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        // quotient reaches 2^24 exactly when the upper numerator covers den
        sat_nxt   = !sub_borrow;
        quot_nxt  = '0;
        rem_nxt   = DEN_W'(num_r[NUM_W-1:SPEED_W]);
        step_nxt  = STEP_W'(SPEED_W - 1);
        state_nxt = sub_borrow ? ST_DIV : ST_FINISH;
      end
      ST_DIV: begin
        quot_nxt = {quot_r[SPEED_W-2:0], !sub_borrow};
        rem_nxt  = sub_borrow ? sub_a[DEN_W-1:0] : sub_diff[DEN_W-1:0];
        step_nxt = step_r - STEP_W'(1);
        if (step_r == '0) begin
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // apply sign, truncate toward zero, saturate
        if (sat_any) begin
          held_nxt = neg_r ? SPEED_MIN : SPEED_MAX;
        end else begin
          held_nxt = neg_r ? (SPEED_W'(0) - quot_r) : quot_r;
        end
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_pos_nxt   = count_r;
          out_speed_nxt = held_r;
          out_upd_nxt   = upd_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control and architectural state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r    <= PERIOD_RESET;
      ppr_r       <= PPR_RESET;
      prev_a_r    <= 1'b1;
      count_r     <= '0;
      win_count_r <= '0;
      win_time_r  <= '0;
      held_r      <= '0;
      out_valid_r <= 1'b0;
      step_r      <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_UPDATE_PERIOD:  period_r <= cfg_wdata;
          REG_PULSES_PER_REV: ppr_r    <= cfg_wdata;
          default: ;
        endcase
      end
      prev_a_r    <= prev_a_nxt;
      count_r     <= count_nxt;
      win_count_r <= win_count_nxt;
      win_time_r  <= win_time_nxt;
      held_r      <= held_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    upd_r       <= upd_nxt;
    neg_r       <= neg_nxt;
    sat_r       <= sat_nxt;
    mag_r       <= mag_nxt;
    elapsed_r   <= elapsed_nxt;
    num_r       <= num_nxt;
    den_r       <= den_nxt;
    rem_r       <= rem_nxt;
    quot_r      <= quot_nxt;
    out_pos_r   <= out_pos_nxt;
    out_speed_r <= out_speed_nxt;
    out_upd_r   <= out_upd_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_position      = $signed(out_pos_r);
  assign out_speed_rpm_q8  = $signed(out_speed_r);
  assign out_speed_updated = out_upd_r;

  // Remainder stays below the divisor through every division step
  a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> rem_r < den_r)
    else $error("division remainder not below divisor");

  // Last division step hands over to the sign and saturation step
  a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && step_r == '0) |=> state_r == ST_FINISH)
    else $error("division did not finish after the last step");

  // Position moves by at most one count per transfer
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (count_r == $past(count_r)) ||
                (count_r == $past(count_r) + 32'd1) ||
                (count_r == $past(count_r) - 32'd1))
    else $error("position moved by more than one count");

  // Held speed changes only out of the finish step
  a_held_source: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(held_r) |-> $past(state_r) == ST_FINISH)
    else $error("held speed changed outside the finish step");

  // A loaded result that reports an update comes from a closed window
  a_upd_window: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && out_free && upd_r) |-> win_count_r == count_r)
    else $error("update reported without a closed window");

endmodule : quadrature_speed_meter_unit

`default_nettype wire
